### rtl/core/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to code point decoder.
package utf8d_pkg;

    localparam int CP_W = 21;

    // Default code point for malformed input (U+FFFD)
    localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

    // Upper bounds of the byte classes
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MAX = 8'hF7;

    // Payload masks of continuation and lead bytes
    localparam logic [7:0] CONT_MASK  = 8'h3F;
    localparam logic [7:0] LEAD2_MASK = 8'h1F;
    localparam logic [7:0] LEAD3_MASK = 8'h0F;
    localparam logic [7:0] LEAD4_MASK = 8'h07;

    // Pending continuation counts set by lead bytes
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } utf8d_in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            end_of_run;
    } utf8d_out_t;

    // Outcome of decoding one byte: up to two results and the next state
    typedef struct packed {
        logic [1:0]      num_results;
        utf8d_out_t      res0;
        utf8d_out_t      res1;
        logic [1:0]      pend_next;
        logic [CP_W-1:0] acc_next;
    } utf8d_step_t;

endpackage

### rtl/core/utf8d_step.sv
// Single-byte decode step: classifies a byte and forms results and next state.
module utf8d_step
    import utf8d_pkg::*;
(
    input  utf8d_in_t       item,
    input  logic [1:0]      pend,
    input  logic [CP_W-1:0] acc,
    input  logic [CP_W-1:0] repl_code,
    output utf8d_step_t     step
);

    logic            pre_err;
    logic            main_valid;
    logic            main_err;
    logic [CP_W-1:0] main_cp;
    logic            tail_err;
    logic [1:0]      pend_mid;
    logic [CP_W-1:0] acc_mid;
    logic [1:0]      pend_dec;
    logic [CP_W-1:0] acc_shift;
    utf8d_out_t      e_pre;
    utf8d_out_t      e_main;
    utf8d_out_t      e_tail;

    // Continuation byte shifts six payload bits into the accumulator
    assign pend_dec  = pend - 2'd1;
    assign acc_shift = {acc[CP_W-7:0], item.data_byte[5:0] & CONT_MASK[5:0]};

    // Handle the byte itself
    always_comb
    begin
        pre_err    = 1'b0;
        main_valid = 1'b0;
        main_err   = 1'b0;
        main_cp    = '0;
        pend_mid   = pend;
        acc_mid    = acc;
        case (item.data_byte) inside
            [8'h00:ASCII_MAX]:
            begin
                pre_err    = (pend != PEND_NONE);
                pend_mid   = PEND_NONE;
                main_valid = 1'b1;
                main_cp    = CP_W'(item.data_byte);
            end
            [8'h80:CONT_MAX]:
            begin
                if (pend != PEND_NONE)
                begin
                    acc_mid    = acc_shift;
                    pend_mid   = pend_dec;
                    main_valid = (pend_dec == PEND_NONE);
                    main_cp    = acc_shift;
                end
                else
                begin
                    main_valid = 1'b1;
                    main_err   = 1'b1;
                    main_cp    = repl_code;
                end
            end
            [8'hC0:LEAD2_MAX]:
            begin
                pend_mid = PEND_ONE;
                acc_mid  = CP_W'(item.data_byte & LEAD2_MASK);
            end
            [8'hE0:LEAD3_MAX]:
            begin
                pend_mid = PEND_TWO;
                acc_mid  = CP_W'(item.data_byte & LEAD3_MASK);
            end
            [8'hF0:LEAD4_MAX]:
            begin
                pend_mid = PEND_THREE;
                acc_mid  = CP_W'(item.data_byte & LEAD4_MASK);
            end
            default:
            begin
                main_valid = 1'b1;
                main_err   = 1'b1;
                main_cp    = repl_code;
                pend_mid   = PEND_NONE;
            end
        endcase
    end

    // End of string: flag an unfinished sequence
    assign tail_err = item.last_byte && (pend_mid != PEND_NONE);

    assign e_pre  = '{code_point: repl_code, is_error: 1'b1, end_of_run: 1'b0};
    assign e_main = '{code_point: main_cp, is_error: main_err, end_of_run: 1'b0};
    assign e_tail = '{code_point: repl_code, is_error: 1'b1, end_of_run: 1'b0};

    // Pack the candidate results in order and clear the state at end of string
    always_comb
    begin
        step.pend_next = item.last_byte ? PEND_NONE : pend_mid;
        step.acc_next  = item.last_byte ? '0 : acc_mid;
        step.res0 = e_main;
        step.res1 = e_tail;
        if (pre_err)
        begin
            step.res0 = e_pre;
            step.res1 = e_main;
        end
        else if (!main_valid)
        begin
            step.res0 = e_tail;
        end
        step.num_results = 2'(pre_err) + 2'(main_valid) + 2'(tail_err);
        // Mark the last result caused by this byte
        if (step.num_results == 2'd1)
        begin
            step.res0.end_of_run = 1'b1;
        end
        else if (step.num_results == 2'd2)
        begin
            step.res1.end_of_run = 1'b1;
        end
    end

endmodule

### rtl/core/utf8d_out_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while cp_ready is high.
module utf8d_out_fifo
    import utf8d_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_n,
    input  utf8d_out_t       push0,
    input  utf8d_out_t       push1,
    output logic [CNT_W-1:0] free_slots,
    output logic             cp_valid,
    input  logic             cp_ready,
    output utf8d_out_t       cp_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    utf8d_out_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W-1:0] tail_inc2;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop        = cp_valid && cp_ready;
    assign cp_valid   = (count_reg != '0);
    assign cp_item    = mem_reg[head_reg];
    assign free_slots = CNT_W'(DEPTH) - count_reg;

    // Advance pointers with wrap at the queue depth
    assign tail_inc  = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
    assign tail_inc2 = (tail_inc == PTR_LAST) ? '0 : tail_inc + PTR_W'(1);

    always_comb
    begin
        case (push_n)
            2'd1:    tail_next = tail_inc;
            2'd2:    tail_next = tail_inc2;
            default: tail_next = tail_reg;
        endcase
        head_next = head_reg;
        if (pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    // Hold queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Write incoming results
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[tail_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[tail_inc] <= push1;
        end
    end

endmodule

### rtl/core/utf8_to_code_point_decoder.sv
// Top level of the UTF-8 to code point decoder.
// Decodes a UTF-8 byte stream, one byte per transaction on the byte channel,
// into code points on the cp channel. A new byte is taken every cycle while
// the result queue has room for its results; each byte gives zero, one or two
// results and the cp channel delivers one result per cycle while cp_ready is
// high, so the sustained rate is one byte per cycle while bytes give at most
// one result, and lower for bytes that give two (an ASCII byte that breaks a
// pending sequence). A byte passes an input register and the decode logic into
// the result queue (OUT_DEPTH entries); it waits in the input register while
// the queue lacks room for all of its results, and its results are offered
// once written to the queue. Malformed input returns repl_reg (written through
// cfg_we/cfg_wdata, U+FFFD after reset) with is_error set; end_of_run marks
// the final result of each byte. No overlong or surrogate checks are made.
module utf8_to_code_point_decoder
    import utf8d_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [CP_W-1:0] cfg_wdata,
    input  logic            byte_valid,
    output logic            byte_ready,
    input  utf8d_in_t       byte_item,
    output logic            cp_valid,
    input  logic            cp_ready,
    output utf8d_out_t      cp_item
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic            in_valid_reg;
    logic            in_valid_next;
    utf8d_in_t       in_item_reg;
    logic [1:0]      pend_reg;
    logic [CP_W-1:0] acc_reg;
    logic [CP_W-1:0] repl_reg;
    utf8d_step_t     step;
    logic [CNT_W-1:0] free_slots;
    logic            consume;
    logic [1:0]      push_n;

    // Decode the held byte once the queue has room for all of its results
    assign consume       = in_valid_reg && (CNT_W'(step.num_results) <= free_slots);
    assign byte_ready    = !in_valid_reg || consume;
    assign in_valid_next = byte_valid || (in_valid_reg && !consume);
    assign push_n        = consume ? step.num_results : 2'd0;

    // Hold the input transaction and the decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= PEND_NONE;
            acc_reg      <= '0;
            repl_reg     <= REPL_RESET;
        end
        else
        begin
            if (byte_ready)
            begin
                in_valid_reg <= in_valid_next;
            end
            if (consume)
            begin
                pend_reg <= step.pend_next;
                acc_reg  <= step.acc_next;
            end
            if (cfg_we)
            begin
                repl_reg <= cfg_wdata;
            end
        end
    end

    // Capture payload of an accepted transaction
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_item_reg <= byte_item;
        end
    end

    utf8d_step u_step (
        .item      (in_item_reg),
        .pend      (pend_reg),
        .acc       (acc_reg),
        .repl_code (repl_reg),
        .step      (step)
    );

    utf8d_out_fifo #(
        .DEPTH (OUT_DEPTH),
        .CNT_W (CNT_W)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push0      (step.res0),
        .push1      (step.res1),
        .free_slots (free_slots),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_item    (cp_item)
    );

endmodule

### rtl/core/utf8d_checker.sv
// Port-level checks for the UTF-8 decoder, bound to the top level.
module utf8d_port_checks
    import utf8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_ready,
    input  utf8d_in_t  byte_item,
    input  logic       cp_valid,
    input  logic       cp_ready,
    input  utf8d_out_t cp_item
);

    // No result is offered while in reset
    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !cp_valid)
        else $error("result offered during reset");

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_ready |=> cp_valid && $stable(cp_item))
        else $error("stalled result changed or dropped");

    // A decoded character always closes the results of its byte
    a_good_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_item.is_error |-> cp_item.end_of_run)
        else $error("non-error result not marked end_of_run");

    // An empty output side never blocks the input side for long
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !cp_valid && !byte_valid && $past(!cp_valid && !byte_valid && rst_n)
        |-> byte_ready)
        else $error("input stalled while decoder is drained");

endmodule

bind utf8_to_code_point_decoder utf8d_port_checks u_utf8d_port_checks (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .cp_valid   (cp_valid),
    .cp_ready   (cp_ready),
    .cp_item    (cp_item)
);

### bench/utf8d_checker.sv
// Checker for the UTF-8 decoder: predicts code points per byte and compares the cp channel.
`timescale 1ns / 100ps

module utf8d_checker
    import utf8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [CP_W-1:0] cfg_wdata,
    input  logic            byte_valid,
    input  logic            byte_ready,
    input  utf8d_in_t       byte_item,
    input  logic            cp_valid,
    input  logic            cp_ready,
    input  utf8d_out_t      cp_item,
    output int              mismatch_count,
    output int              results_due
);

    // Predictor state, kept apart from the design
    logic [1:0]      pend_cnt;
    logic [CP_W-1:0] acc;
    logic [CP_W-1:0] repl_code;

    utf8d_out_t expected_cps [$];

    function automatic utf8d_out_t make_cp(input logic [CP_W-1:0] cp, input logic err);
        utf8d_out_t r;
        r.code_point = cp;
        r.is_error   = err;
        r.end_of_run = 1'b0;
        return r;
    endfunction

    // Decode one byte and queue the code points it should give
    task automatic predict_byte(input utf8d_in_t b);
        utf8d_out_t r [2];
        int         n;
        logic [7:0] c;
        n = 0;
        c = b.data_byte;
        if (c <= ASCII_MAX)
        begin
            if (pend_cnt != PEND_NONE)
            begin
                r[n] = make_cp(repl_code, 1'b1);
                n++;
                pend_cnt = PEND_NONE;
            end
            r[n] = make_cp(CP_W'(c), 1'b0);
            n++;
        end
        else if (c <= CONT_MAX)
        begin
            if (pend_cnt != PEND_NONE)
            begin
                acc = (acc << 6) | CP_W'(c & CONT_MASK);
                pend_cnt = pend_cnt - 2'd1;
                if (pend_cnt == PEND_NONE)
                begin
                    r[n] = make_cp(acc, 1'b0);
                    n++;
                end
            end
            else
            begin
                r[n] = make_cp(repl_code, 1'b1);
                n++;
            end
        end
        else if (c <= LEAD2_MAX)
        begin
            pend_cnt = PEND_ONE;
            acc = CP_W'(c & LEAD2_MASK);
        end
        else if (c <= LEAD3_MAX)
        begin
            pend_cnt = PEND_TWO;
            acc = CP_W'(c & LEAD3_MASK);
        end
        else if (c <= LEAD4_MAX)
        begin
            pend_cnt = PEND_THREE;
            acc = CP_W'(c & LEAD4_MASK);
        end
        else
        begin
            r[n] = make_cp(repl_code, 1'b1);
            n++;
            pend_cnt = PEND_NONE;
        end

        // End of string: flag an unfinished sequence, then clear
        if (b.last_byte)
        begin
            if (pend_cnt != PEND_NONE)
            begin
                r[n] = make_cp(repl_code, 1'b1);
                n++;
            end
            pend_cnt = PEND_NONE;
            acc = '0;
        end

        if (n > 0)
            r[n-1].end_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_cps.insert(expected_cps.size(), r[i]);
    endtask

    // Compare a received code point with the oldest expectation
    task automatic check_cp(input utf8d_out_t got);
        utf8d_out_t want;
        if (expected_cps.size() == 0)
        begin
            $error("unexpected result: code_point %h is_error %b end_of_run %b",
                   got.code_point, got.is_error, got.end_of_run);
            mismatch_count++;
        end
        else
        begin
            want = expected_cps.pop_front();
            if (got.code_point !== want.code_point)
            begin
                $error("code_point expected %h actual %h", want.code_point, got.code_point);
                mismatch_count++;
            end
            if (got.is_error !== want.is_error)
            begin
                $error("is_error expected %b actual %b", want.is_error, got.is_error);
                mismatch_count++;
            end
            if (got.end_of_run !== want.end_of_run)
            begin
                $error("end_of_run expected %b actual %b", want.end_of_run, got.end_of_run);
                mismatch_count++;
            end
        end
    endtask

    // Watch both channels; a byte's results pass the input register and the result
    // queue before they can be taken, so check before predicting within one edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt       = PEND_NONE;
            acc            = '0;
            repl_code      = REPL_RESET;
            mismatch_count = 0;
            expected_cps.delete();
            results_due   <= 0;
        end
        else
        begin
            if (cfg_we)
                repl_code = cfg_wdata;
            if (cp_valid && cp_ready)
                check_cp(cp_item);
            if (byte_valid && byte_ready)
                predict_byte(byte_item);
            results_due <= expected_cps.size();
        end
    end

endmodule

### bench/tb_top.sv
// Testbench top for the UTF-8 decoder: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_top;
    import utf8d_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 190;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [CP_W-1:0] cfg_wdata;
    logic            byte_valid;
    logic            byte_ready;
    utf8d_in_t       byte_item;
    logic            cp_valid;
    logic            cp_ready;
    utf8d_out_t      cp_item;

    int mismatch_count;
    int results_due;
    int sent_bytes;
    int quiet_cycles = 0;
    bit tx_idle_on;
    bit rx_idle_on;

    utf8_to_code_point_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_item    (cp_item)
    );

    utf8d_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .byte_item      (byte_item),
        .cp_valid       (cp_valid),
        .cp_ready       (cp_ready),
        .cp_item        (cp_item),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (cp_valid && cp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL utf8_to_code_point_decoder");
            $finish;
        end
    end

    // Receiver: random stalls while enabled
    initial
    begin
        int stall_left;
        stall_left = 0;
        cp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!rx_idle_on)
            begin
                cp_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                cp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                cp_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid          <= 1'b1;
        byte_item.data_byte <= b;
        byte_item.last_byte <= last;
        do
            @(posedge clk);
        while (!byte_ready);
        sent_bytes++;
    endtask

    // Drop valid and wait for every expected result, plus pipeline slack
    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_repl(input logic [CP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            1:       return 8'($urandom_range(0, 127));
            2:       return 8'hC0 | 8'($urandom_range(0, 31));
            3:       return 8'hE0 | 8'($urandom_range(0, 15));
            default: return 8'hF0 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    // Send one complete character sequence of len bytes
    task automatic send_char(input int len, input logic mark_last);
        send_byte(lead_byte(len), mark_last && len == 1);
        for (int i = 1; i < len; i++)
            send_byte(cont_byte(), mark_last && i == len - 1);
    endtask

    // Send a cut-short sequence, a complete one with an extra continuation byte, or a lone random byte
    task automatic send_noise();
        int len;
        int kept;
        len = $urandom_range(2, 4);
        case ($urandom_range(0, 2))
            0:
            begin
                send_byte(lead_byte(len), 1'b0);
                kept = $urandom_range(0, len - 2);
                for (int i = 0; i < kept; i++)
                    send_byte(cont_byte(), 1'b0);
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            1:
            begin
                send_char(len, 1'b0);
                send_byte(cont_byte(), $urandom_range(0, 3) == 0);
            end
            default: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        endcase
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [CP_W-1:0] phase_repl [5];
        int              target;
        phase_repl[0] = '0;
        phase_repl[1] = {CP_W{1'b1}};
        phase_repl[2] = REPL_RESET;
        phase_repl[3] = CP_W'($urandom_range(0, 2097151));
        phase_repl[4] = 21'h10FFFF;

        rst_n          = 1'b0;
        sent_bytes     = 0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        byte_valid    <= 1'b0;
        byte_item     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, default replacement code
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);     // stray continuation
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC2, 1'b0);     // two-byte character
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);     // three-byte character
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);     // four-byte character
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);     // invalid byte
        send_byte(8'hC3, 1'b0);     // ASCII breaks a pending sequence
        send_byte(8'h41, 1'b0);
        send_byte(8'hE0, 1'b0);     // lead while pending drops the old sequence
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE5, 1'b1);     // string ends inside a sequence
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b1);     // invalid last byte while pending
        drain();

        // Random phases, each with its own replacement code and an idling mix
        for (int p = 0; p < 5; p++)
        begin
            write_repl(phase_repl[p]);
            tx_idle_on = (p != 0) && (p != 3);
            rx_idle_on = (p != 0) && (p != 2);
            target = sent_bytes + PHASE_ITEMS;
            while (sent_bytes < target)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_char($urandom_range(1, 4), $urandom_range(0, 5) == 0);
                else
                    send_noise();
                // Hold off now and then until the decoder has emptied
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            drain();
        end

        // Verdict
        if (mismatch_count == 0)
            $display("PASS utf8_to_code_point_decoder");
        else
            $display("FAIL utf8_to_code_point_decoder");
        $finish;
    end

endmodule

### files.f
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_step.sv
rtl/core/utf8d_out_fifo.sv
rtl/core/utf8_to_code_point_decoder.sv
rtl/core/utf8d_checker.sv
bench/utf8d_checker.sv
bench/tb_top.sv
